>>> rtl/core/lacf_pkg.sv
package lacf_pkg;

  // Arrow state codes
  localparam logic [1:0] ARW_EMPTY = 2'd0;
  localparam logic [1:0] ARW_ZERO  = 2'd1;
  localparam logic [1:0] ARW_ONE   = 2'd2;

  // Cell type codes
  localparam logic [4:0] CT_BLANK     = 5'd0;
  localparam logic [4:0] CT_STEM      = 5'd1;
  localparam logic [4:0] CT_AND       = 5'd2;
  localparam logic [4:0] CT_OR        = 5'd3;
  localparam logic [4:0] CT_XOR       = 5'd4;
  localparam logic [4:0] CT_NAND      = 5'd5;
  localparam logic [4:0] CT_WIRE      = 5'd6;
  localparam logic [4:0] CT_CROSSOVER = 5'd7;
  localparam logic [4:0] CT_COPY_N    = 5'd8;
  localparam logic [4:0] CT_COPY_E    = 5'd11;
  localparam logic [4:0] CT_DELETE_N  = 5'd12;
  localparam logic [4:0] CT_DELETE_E  = 5'd15;
  localparam logic [4:0] CT_SINK      = 5'd16;
  localparam logic [4:0] CT_FILE      = 5'd17;

  localparam int NUM_SIDES = 4;

  typedef logic [NUM_SIDES-1:0][1:0] arrows_t;

  // Normalized cell after the first stage
  typedef struct packed {
    logic                 valid;
    logic [4:0]           cell_type;
    logic [NUM_SIDES-1:0] ie;
    logic [NUM_SIDES-1:0] oe;
    arrows_t              a;
    arrows_t              b;
  } norm_t;

  // Per-type evaluation after the second stage
  typedef struct packed {
    logic                 valid;
    logic                 general;
    logic                 res;
    logic                 keep_en;
    logic [1:0]           keep_side;
    logic                 direct_fire;
    logic [NUM_SIDES-1:0] oe;
    arrows_t              a;
    arrows_t              b;
  } eval_t;

  // Final result after the third stage
  typedef struct packed {
    logic    valid;
    logic    fired;
    arrows_t a;
    arrows_t b;
  } result_t;

  function automatic logic [1:0] norm_arrow(input logic present, input logic [1:0] code);
    logic [1:0] v;
    v = (code == 2'd3) ? ARW_ONE : code;
    return present ? v : ARW_EMPTY;
  endfunction

endpackage

>>> rtl/core/lacf_norm.sv
module lacf_norm (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [4:0]          cell_type,
  input  logic [3:0]          in_exists,
  input  lacf_pkg::arrows_t   in_raw,
  input  logic [3:0]          out_exists,
  input  lacf_pkg::arrows_t   out_raw,
  output lacf_pkg::norm_t     norm
);

  lacf_pkg::norm_t norm_next;

  // Mask absent arrows and fold code 3 onto token one
  always_comb begin
    norm_next.valid     = in_valid;
    norm_next.cell_type = cell_type;
    norm_next.ie        = in_exists;
    norm_next.oe        = out_exists;
    for (int d = 0; d < lacf_pkg::NUM_SIDES; d++) begin
      norm_next.a[d] = lacf_pkg::norm_arrow(in_exists[d], in_raw[d]);
      norm_next.b[d] = lacf_pkg::norm_arrow(out_exists[d], out_raw[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      norm.valid <= 1'b0;
    end else begin
      norm.valid <= norm_next.valid;
    end
    norm.cell_type <= norm_next.cell_type;
    norm.ie        <= norm_next.ie;
    norm.oe        <= norm_next.oe;
    norm.a         <= norm_next.a;
    norm.b         <= norm_next.b;
  end

endmodule

>>> rtl/core/lacf_eval.sv
module lacf_eval (
  input  logic            clk,
  input  logic            rst,
  input  lacf_pkg::norm_t norm,
  output lacf_pkg::eval_t ev
);

  lacf_pkg::eval_t ev_next;

  logic [3:0] filled;
  logic [3:0] one;
  logic       all_ok;
  logic       and_v;
  logic       or_v;
  logic       xor_v;
  logic [1:0] side;
  logic       others;
  logic       other_one;
  logic [1:0] last;
  logic       ctl;
  logic       wire_res;

  always_comb begin
    for (int d = 0; d < lacf_pkg::NUM_SIDES; d++) begin
      filled[d] = (norm.a[d] != lacf_pkg::ARW_EMPTY);
      one[d]    = (norm.a[d] == lacf_pkg::ARW_ONE);
    end
    all_ok = &(filled | ~norm.ie);
    and_v  = &(one | ~norm.ie);
    or_v   = |(one & norm.ie);
    xor_v  = ^(one & norm.ie);
    side   = norm.cell_type[1:0];

    // Wire: token of the highest filled side
    wire_res = 1'b0;
    for (int d = 0; d < lacf_pkg::NUM_SIDES; d++) begin
      if (filled[d]) begin
        wire_res = one[d];
      end
    end

    // Control inputs other than the data side
    others    = 1'b0;
    other_one = 1'b0;
    last      = 2'd0;
    ctl       = 1'b0;
    for (int i = 0; i < lacf_pkg::NUM_SIDES; i++) begin
      if ((2'(i) != side) && filled[i]) begin
        others    = 1'b1;
        other_one = other_one | one[i];
        last      = 2'(i);
        ctl       = one[i];
      end
    end

    ev_next.valid       = norm.valid;
    ev_next.general     = 1'b0;
    ev_next.res         = 1'b0;
    ev_next.keep_en     = 1'b0;
    ev_next.keep_side   = side;
    ev_next.direct_fire = 1'b0;
    ev_next.oe          = norm.oe;
    ev_next.a           = norm.a;
    ev_next.b           = norm.b;

    case (norm.cell_type) inside
      lacf_pkg::CT_AND: begin
        ev_next.general = all_ok;
        ev_next.res     = and_v;
      end
      lacf_pkg::CT_OR: begin
        ev_next.general = all_ok;
        ev_next.res     = or_v;
      end
      lacf_pkg::CT_XOR: begin
        ev_next.general = all_ok;
        ev_next.res     = xor_v;
      end
      lacf_pkg::CT_NAND: begin
        ev_next.general = all_ok;
        ev_next.res     = ~and_v;
      end
      lacf_pkg::CT_WIRE: begin
        ev_next.general = |filled;
        ev_next.res     = wire_res;
      end
      lacf_pkg::CT_CROSSOVER: begin
        // Move each filled input to the opposite output if that one is free
        for (int d = 0; d < lacf_pkg::NUM_SIDES; d++) begin
          if (filled[d] && norm.oe[d ^ 1] && (norm.b[d ^ 1] == lacf_pkg::ARW_EMPTY)) begin
            ev_next.b[d ^ 1]    = norm.a[d];
            ev_next.a[d]        = lacf_pkg::ARW_EMPTY;
            ev_next.direct_fire = 1'b1;
          end
        end
      end
      [lacf_pkg::CT_COPY_N:lacf_pkg::CT_COPY_E]: begin
        ev_next.general = filled[side] && others;
        ev_next.res     = one[side];
        ev_next.keep_en = other_one;
      end
      [lacf_pkg::CT_DELETE_N:lacf_pkg::CT_DELETE_E]: begin
        if (filled[side] && others) begin
          if (ctl) begin
            ev_next.a[side]     = lacf_pkg::ARW_EMPTY;
            ev_next.a[last]     = lacf_pkg::ARW_EMPTY;
            ev_next.direct_fire = 1'b1;
          end else begin
            ev_next.general = 1'b1;
            ev_next.res     = one[side];
          end
        end
      end
      lacf_pkg::CT_SINK: begin
        ev_next.general = 1'b1;
        ev_next.res     = 1'b0;
      end
      default: begin
        // Blank, stem, file and unused codes hold the arrows
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev.valid <= 1'b0;
    end else begin
      ev.valid <= ev_next.valid;
    end
    ev.general     <= ev_next.general;
    ev.res         <= ev_next.res;
    ev.keep_en     <= ev_next.keep_en;
    ev.keep_side   <= ev_next.keep_side;
    ev.direct_fire <= ev_next.direct_fire;
    ev.oe          <= ev_next.oe;
    ev.a           <= ev_next.a;
    ev.b           <= ev_next.b;
  end

endmodule

>>> rtl/core/lacf_apply.sv
module lacf_apply (
  input  logic              clk,
  input  logic              rst,
  input  lacf_pkg::eval_t   ev,
  output lacf_pkg::result_t result
);

  lacf_pkg::result_t result_next;

  logic       blocked;
  logic       go;
  logic [1:0] token;

  always_comb begin
    blocked = 1'b0;
    for (int d = 0; d < lacf_pkg::NUM_SIDES; d++) begin
      blocked = blocked | (ev.b[d] != lacf_pkg::ARW_EMPTY);
    end
    go    = ev.general && !blocked;
    token = ev.res ? lacf_pkg::ARW_ONE : lacf_pkg::ARW_ZERO;

    result_next.valid = ev.valid;
    result_next.fired = ev.direct_fire | go;
    result_next.a     = ev.a;
    result_next.b     = ev.b;
    // Consume inputs, except a kept side when keep_en is set, and fill every existing output
    if (go) begin
      for (int d = 0; d < lacf_pkg::NUM_SIDES; d++) begin
        if (!(ev.keep_en && (2'(d) == ev.keep_side))) begin
          result_next.a[d] = lacf_pkg::ARW_EMPTY;
        end
        if (ev.oe[d]) begin
          result_next.b[d] = token;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else begin
      result.valid <= result_next.valid;
    end
    result.fired <= result_next.fired;
    result.a     <= result_next.a;
    result.b     <= result_next.b;
  end

endmodule

>>> rtl/core/logic_automaton_cell_fire_top.sv
// Firing rule of one logic automaton cell. Pulse start with a cell type and its
// four input and four output arrows; when they leave the last register stage, done is
// high for one cycle with fired and the updated arrow states. The block takes a
// new transfer in every cycle, so busy never rises, and up to three cells are in
// flight at once in the three register stages (normalize, evaluate by type,
// apply the firing). Results cannot be held off: the receiver must take each
// one in the cycle that done marks.
module logic_automaton_cell_fire_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [4:0] cell_type,
  input  logic [3:0] in_exists,
  input  logic [1:0] in_state_north,
  input  logic [1:0] in_state_south,
  input  logic [1:0] in_state_west,
  input  logic [1:0] in_state_east,
  input  logic [3:0] out_exists,
  input  logic [1:0] out_state_north,
  input  logic [1:0] out_state_south,
  input  logic [1:0] out_state_west,
  input  logic [1:0] out_state_east,
  output logic       done,
  output logic       fired,
  output logic [1:0] new_in_north,
  output logic [1:0] new_in_south,
  output logic [1:0] new_in_west,
  output logic [1:0] new_in_east,
  output logic [1:0] new_out_north,
  output logic [1:0] new_out_south,
  output logic [1:0] new_out_west,
  output logic [1:0] new_out_east
);

  lacf_pkg::arrows_t in_raw;
  lacf_pkg::arrows_t out_raw;
  lacf_pkg::norm_t   norm;
  lacf_pkg::eval_t   ev;
  lacf_pkg::result_t result;

  // The pipeline never stalls, so every start is a transfer
  assign busy = 1'b0;

  // Gather sides in index order: north, south, west, east
  assign in_raw  = {in_state_east, in_state_west, in_state_south, in_state_north};
  assign out_raw = {out_state_east, out_state_west, out_state_south, out_state_north};

  // Stage one: mask absent arrows, fold state code 3 onto token one
  lacf_norm u_norm (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start),
    .cell_type  (cell_type),
    .in_exists  (in_exists),
    .in_raw     (in_raw),
    .out_exists (out_exists),
    .out_raw    (out_raw),
    .norm       (norm)
  );

  // Stage two: gate values, wire, copy and delete control, crossover moves, sink
  lacf_eval u_eval (
    .clk  (clk),
    .rst  (rst),
    .norm (norm),
    .ev   (ev)
  );

  // Stage three: check outputs for tokens, consume inputs, fill outputs
  lacf_apply u_apply (
    .clk    (clk),
    .rst    (rst),
    .ev     (ev),
    .result (result)
  );

  assign done          = result.valid;
  assign fired         = result.fired;
  assign new_in_north  = result.a[0];
  assign new_in_south  = result.a[1];
  assign new_in_west   = result.a[2];
  assign new_in_east   = result.a[3];
  assign new_out_north = result.b[0];
  assign new_out_south = result.b[1];
  assign new_out_west  = result.b[2];
  assign new_out_east  = result.b[3];

endmodule
